// File: src/line_context_selector_assert.svh
// Assertion macros used by the line context selector module.
`ifndef LINE_CONTEXT_SELECTOR_ASSERT_SVH
`define LINE_CONTEXT_SELECTOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCS_ASSERT_IMP(label, ante, cons, msg)
`define LCS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: src/lcs_pkg.sv
// Types, codes and helpers for the line context selector.
package lcs_pkg;

  localparam int unsigned LCS_MAX_BEFORE = 16;
  localparam int unsigned LCS_LINE_BITS  = 32;

  localparam int unsigned LCS_BEFORE_W = 5;
  localparam int unsigned LCS_AFTER_W  = 8;
  localparam int unsigned LCS_OMODE_W  = 3;
  localparam int unsigned LCS_CFG_W    = 8;
  localparam int unsigned LCS_IDX_W    = 2;
  localparam int unsigned LCS_OUT_W    = 32;

  // configuration register indexes
  localparam logic [LCS_IDX_W-1:0] REG_BEFORE_COUNT = 2'd0;
  localparam logic [LCS_IDX_W-1:0] REG_AFTER_COUNT  = 2'd1;
  localparam logic [LCS_IDX_W-1:0] REG_OUTPUT_MODE  = 2'd2;
  localparam logic [LCS_IDX_W-1:0] REG_INVERT_MATCH = 2'd3;

  // output modes
  localparam logic [LCS_OMODE_W-1:0] OMODE_TEXT    = 3'd0;
  localparam logic [LCS_OMODE_W-1:0] OMODE_COMPACT = 3'd1;
  localparam logic [LCS_OMODE_W-1:0] OMODE_JSON    = 3'd2;
  localparam logic [LCS_OMODE_W-1:0] OMODE_COUNT   = 3'd3;
  localparam logic [LCS_OMODE_W-1:0] OMODE_FILES   = 3'd4;

  // input item codes
  localparam logic ITEM_LINE = 1'b0;
  localparam logic ITEM_EOF  = 1'b1;

  typedef enum logic [1:0] {
    KIND_MATCH  = 2'd0,
    KIND_BEFORE = 2'd1,
    KIND_AFTER  = 2'd2,
    KIND_FILE   = 2'd3
  } lcs_kind_e;

  typedef struct packed {
    logic mode;
    logic line_matched;
  } lcs_in_t;

  typedef struct packed {
    logic [LCS_OUT_W-1:0] line_num;
    lcs_kind_e            kind;
    logic                 separator_before;
    logic [LCS_OUT_W-1:0] match_count;
    logic                 last;
  } lcs_out_t;

  // chain operation from the controller
  typedef struct packed {
    logic push;
    logic flush;
  } lcs_chain_ctrl_t;

  // per-cell operation
  typedef struct packed {
    logic load;
    logic shift;
  } lcs_cell_ctrl_t;

  function automatic lcs_out_t lcs_mk_out(logic [LCS_OUT_W-1:0] ln, lcs_kind_e kd,
                                          logic sep, logic [LCS_OUT_W-1:0] cnt,
                                          logic lst);
    lcs_out_t r;
    r.line_num         = ln;
    r.kind             = kd;
    r.separator_before = sep;
    r.match_count      = cnt;
    r.last             = lst;
    return r;
  endfunction

endpackage

// File: src/line_context_selector.sv
// Line context selector: numbers lines and picks match, before and after lines.
// A line item is taken only in S_IDLE; in modes that show lines a selected one then flushes
// each stored line of the cell chain (ring fill, at most MAX_BEFORE) and then the match line,
// one line per cycle while the output slot is free; other items emit at most one beat.
// Results leave a registered output stage, up to one beat a cycle as out_ready_i allows.
// rst_ni clears control registers and per-file state at once; chain cells, pend_q and out_q are not reset.
`include "line_context_selector_assert.svh"
module line_context_selector #(
  parameter int unsigned MAX_BEFORE = lcs_pkg::LCS_MAX_BEFORE,
  parameter int unsigned LINE_BITS  = lcs_pkg::LCS_LINE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lcs_pkg::lcs_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lcs_pkg::lcs_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lcs_pkg::LCS_IDX_W-1:0]       cfg_index_i,
  input  logic [lcs_pkg::LCS_CFG_W-1:0]       cfg_data_i
);
  import lcs_pkg::*;

  localparam int unsigned FILL_W = $clog2(MAX_BEFORE + 1);
  localparam int unsigned CMP_W  = (FILL_W > LCS_BEFORE_W) ? FILL_W : LCS_BEFORE_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FLUSH  = 4'b0010,
    S_MATCH  = 4'b0100,
    S_SINGLE = 4'b1000
  } lcs_state_e;

  lcs_state_e               state_q, state_d;
  logic [LCS_BEFORE_W-1:0]  before_q;
  logic [LCS_AFTER_W-1:0]   after_q;
  logic [LCS_OMODE_W-1:0]   omode_q;
  logic                     invert_q;

  logic [LINE_BITS-1:0]     lc_q, lc_d;
  logic [LINE_BITS-1:0]     le_q, le_d;
  logic [LCS_OUT_W-1:0]     total_q, total_d;
  logic [LCS_AFTER_W-1:0]   after_left_q, after_left_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [FILL_W-1:0]        cnt_q, cnt_d;
  logic [FILL_W-1:0]        k_q, k_d;
  logic                     sep_q, sep_d;
  logic                     file_done_q, file_done_d;
  lcs_out_t                 pend_q, pend_d;
  logic                     out_valid_q, out_valid_d;
  lcs_out_t                 out_q, out_d;

  logic                     text;
  logic                     slot_free;
  logic                     sel;
  logic [FILL_W-1:0]        b_eff;
  logic [LINE_BITS-1:0]     lc_inc;
  logic [LCS_OUT_W-1:0]     total_inc;
  logic [LINE_BITS-1:0]     gap;
  logic                     sep_hit;
  logic [LINE_BITS-1:0]     head;
  logic                     emit;
  lcs_out_t                 res;
  lcs_chain_ctrl_t          chain_ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= '0;
      after_q  <= '0;
      omode_q  <= '0;
      invert_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BEFORE_COUNT: before_q <= cfg_data_i[LCS_BEFORE_W-1:0];
        REG_AFTER_COUNT:  after_q  <= cfg_data_i[LCS_AFTER_W-1:0];
        REG_OUTPUT_MODE:  omode_q  <= cfg_data_i[LCS_OMODE_W-1:0];
        REG_INVERT_MATCH: invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign text = !(omode_q == OMODE_JSON || omode_q == OMODE_COUNT ||
                  omode_q == OMODE_FILES);
  assign slot_free = !out_valid_q || out_ready_i;
  assign sel = in_data_i.line_matched ^ invert_q;
  assign b_eff = (CMP_W'(before_q) > CMP_W'(MAX_BEFORE)) ? FILL_W'(MAX_BEFORE)
                                                         : FILL_W'(before_q);
  assign lc_inc    = (lc_q != '1) ? lc_q + LINE_BITS'(1) : lc_q;
  assign total_inc = (total_q != '1) ? total_q + LCS_OUT_W'(1) : total_q;
  assign gap = LINE_BITS'(after_q) + LINE_BITS'(b_eff) + LINE_BITS'(1);
  assign sep_hit = text && (omode_q != OMODE_COMPACT) && (le_q != '0) &&
                   (lc_inc > le_q) && ((lc_inc - le_q) > gap);

  lcs_chain #(
    .DEPTH  (MAX_BEFORE),
    .W      (LINE_BITS),
    .FILL_W (FILL_W)
  ) u_chain (
    .clk_i  (clk_i),
    .ctrl_i (chain_ctrl),
    .fill_i (fill_q),
    .new_i  (lc_inc),
    .head_o (head)
  );

  always_comb begin
    state_d      = state_q;
    lc_d         = lc_q;
    le_d         = le_q;
    total_d      = total_q;
    after_left_d = after_left_q;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    sep_d        = sep_q;
    file_done_d  = file_done_q;
    pend_d       = pend_q;
    emit         = 1'b0;
    res          = pend_q;
    chain_ctrl   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.mode == ITEM_EOF) begin
            if ((omode_q == OMODE_JSON || omode_q == OMODE_COUNT) && total_q != '0) begin
              pend_d  = lcs_mk_out('0, KIND_FILE, 1'b0, total_q, 1'b1);
              state_d = S_SINGLE;
            end
            lc_d         = '0;
            le_d         = '0;
            total_d      = '0;
            after_left_d = '0;
            fill_d       = '0;
            file_done_d  = 1'b0;
          end else if (!file_done_q) begin
            lc_d = lc_inc;
            if (sel) begin
              total_d = total_inc;
              if (omode_q == OMODE_FILES) begin
                pend_d      = lcs_mk_out('0, KIND_FILE, 1'b0, total_inc, 1'b1);
                file_done_d = 1'b1;
                state_d     = S_SINGLE;
              end else if (omode_q != OMODE_COUNT) begin
                sep_d        = sep_hit;
                cnt_d        = fill_q;
                k_d          = (fill_q < b_eff) ? fill_q : b_eff;
                after_left_d = after_q;
                fill_d       = '0;
                state_d      = (fill_q != '0) ? S_FLUSH : S_MATCH;
              end
            end else if (after_left_q != '0) begin
              if (omode_q != OMODE_COUNT && omode_q != OMODE_FILES) begin
                pend_d  = lcs_mk_out(LCS_OUT_W'(lc_inc), KIND_AFTER, 1'b0, total_q, 1'b1);
                state_d = S_SINGLE;
                if (text) begin
                  le_d = lc_inc;
                end
              end
              after_left_d = after_left_q - LCS_AFTER_W'(1);
            end else if (b_eff != '0) begin
              chain_ctrl.push = 1'b1;
              if (fill_q != FILL_W'(MAX_BEFORE)) begin
                fill_d = fill_q + FILL_W'(1);
              end
            end
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          chain_ctrl.flush = 1'b1;
          if (cnt_q <= k_q && (!text || head > le_q)) begin
            emit  = 1'b1;
            res   = lcs_mk_out(LCS_OUT_W'(head), KIND_BEFORE, sep_q, total_q, 1'b0);
            sep_d = 1'b0;
            if (text) begin
              le_d = head;
            end
          end
          cnt_d = cnt_q - FILL_W'(1);
          if (cnt_q == FILL_W'(1)) begin
            state_d = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        if (slot_free) begin
          emit    = 1'b1;
          res     = lcs_mk_out(LCS_OUT_W'(lc_q), KIND_MATCH, sep_q, total_q, 1'b1);
          state_d = S_IDLE;
          if (text) begin
            le_d = lc_q;
          end
        end
      end
      S_SINGLE: begin
        if (slot_free) begin
          emit    = 1'b1;
          res     = pend_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lc_q         <= '0;
      le_q         <= '0;
      total_q      <= '0;
      after_left_q <= '0;
      fill_q       <= '0;
      cnt_q        <= '0;
      k_q          <= '0;
      sep_q        <= 1'b0;
      file_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lc_q         <= lc_d;
      le_q         <= le_d;
      total_q      <= total_d;
      after_left_q <= after_left_d;
      fill_q       <= fill_d;
      cnt_q        <= cnt_d;
      k_q          <= k_d;
      sep_q        <= sep_d;
      file_done_q  <= file_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  `LCS_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_W'(MAX_BEFORE), "ring fill above depth")
  `LCS_ASSERT_IMP(a_flush_cnt, state_q == S_FLUSH, cnt_q != '0, "flush with nothing left")
  `LCS_ASSERT_IMP(a_before_not_last, out_valid_o && out_data_o.kind == KIND_BEFORE,
                  !out_data_o.last, "before beat marked last")
  `LCS_ASSERT_NXT(a_eof_clear, in_valid_i && in_ready_o && in_data_i.mode == ITEM_EOF,
                  fill_q == '0 && total_q == '0 && lc_q == '0, "file state kept after eof")

endmodule

// File: src/lcs_cell.sv
// One cell of the before-context chain: holds one stored line number.
module lcs_cell #(
  parameter int unsigned W = 32
) (
  input  logic                    clk_i,
  input  lcs_pkg::lcs_cell_ctrl_t ctrl_i,
  input  logic [W-1:0]            new_i,
  input  logic [W-1:0]            nbr_i,
  output logic [W-1:0]            val_o
);
  import lcs_pkg::*;

  logic [W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.load) begin
      val_d = new_i;
    end else if (ctrl_i.shift) begin
      val_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: src/lcs_chain.sv
// Row of line-number cells; oldest entry sits in cell 0, flush shifts toward it.
module lcs_chain #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned W      = 32,
  parameter int unsigned FILL_W = 5
) (
  input  logic                     clk_i,
  input  lcs_pkg::lcs_chain_ctrl_t ctrl_i,
  input  logic [FILL_W-1:0]        fill_i,
  input  logic [W-1:0]             new_i,
  output logic [W-1:0]             head_o
);
  import lcs_pkg::*;

  logic [W-1:0] val   [DEPTH];
  logic [W-1:0] nbr   [DEPTH];
  logic         full;
  logic         shift;

  assign full  = (fill_i == FILL_W'(DEPTH));
  assign shift = ctrl_i.flush || (ctrl_i.push && full);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lcs_cell_ctrl_t cctrl;

    assign cctrl.load  = ctrl_i.push && !full && (fill_i == FILL_W'(i));
    assign cctrl.shift = shift;

    if (i == DEPTH - 1) begin : g_tail
      assign nbr[i] = ctrl_i.push ? new_i : val[i];
    end else begin : g_mid
      assign nbr[i] = val[i+1];
    end

    lcs_cell #(
      .W (W)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cctrl),
      .new_i  (new_i),
      .nbr_i  (nbr[i]),
      .val_o  (val[i])
    );
  end

  assign head_o = val[0];

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for line_context_selector: directed files, then randomized files.
`timescale 1ns / 1ps
module tb_top;
  import lcs_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 2 * LCS_MAX_BEFORE + 8;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned RANDOM_PHASES = 13;
  localparam int unsigned PHASE_ITEMS   = 24;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  lcs_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  lcs_out_t             out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [LCS_IDX_W-1:0] cfg_index_i;
  logic [LCS_CFG_W-1:0] cfg_data_i;

  line_context_selector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // register copies
  logic [LCS_BEFORE_W-1:0] before_reg;
  logic [LCS_AFTER_W-1:0]  after_reg;
  logic [LCS_OMODE_W-1:0]  omode_reg;
  logic                    invert_reg;

  // per-file selector state
  logic [31:0] ring_lines [LCS_MAX_BEFORE];
  logic [3:0]  ring_head;
  logic [4:0]  ring_fill;
  logic [31:0] line_no;
  logic [7:0]  after_left;
  logic [31:0] last_shown;
  logic [31:0] selected_total;
  logic        file_done;

  lcs_out_t    pending_lines [$];
  lcs_out_t    oldest_line;
  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned items_sent;
  int unsigned settings_used;
  int unsigned cycles;
  logic        steady_flow;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still outstanding", $time, pending_lines.size());
      $display("[line_context_selector] ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lcs_in_t line_item(logic matched);
    lcs_in_t it;
    it.mode         = ITEM_LINE;
    it.line_matched = matched;
    return it;
  endfunction

  function automatic lcs_in_t eof_item();
    lcs_in_t it;
    it.mode         = ITEM_EOF;
    it.line_matched = logic'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic lcs_out_t make_line(logic [31:0] ln, lcs_kind_e kd, logic sep);
    lcs_out_t r;
    r.line_num         = ln;
    r.kind             = kd;
    r.separator_before = sep;
    r.match_count      = selected_total;
    r.last             = 1'b0;
    return r;
  endfunction

  task automatic reset_file_state();
    ring_head      = '0;
    ring_fill      = '0;
    line_no        = '0;
    after_left     = '0;
    last_shown     = '0;
    selected_total = '0;
    file_done      = 1'b0;
  endtask

  task automatic commit_reg(logic [LCS_IDX_W-1:0] idx, logic [LCS_CFG_W-1:0] data);
    case (idx)
      REG_BEFORE_COUNT: before_reg = data[LCS_BEFORE_W-1:0];
      REG_AFTER_COUNT:  after_reg  = data[LCS_AFTER_W-1:0];
      REG_OUTPUT_MODE:  omode_reg  = data[LCS_OMODE_W-1:0];
      default:          invert_reg = data[0];
    endcase
  endtask

  // predicts the beats caused by one accepted item and queues them
  task automatic select_lines(lcs_in_t it);
    lcs_out_t    beats [LCS_MAX_BEFORE + 2];
    int unsigned n;
    int unsigned b;
    int unsigned a;
    int unsigned k;
    int unsigned idx;
    logic        text;
    logic        sel;
    logic        sep;
    logic [31:0] ln;
    n    = 0;
    b    = (before_reg > LCS_MAX_BEFORE) ? LCS_MAX_BEFORE : int'(before_reg);
    a    = after_reg;
    text = (omode_reg != OMODE_JSON) && (omode_reg != OMODE_COUNT) &&
           (omode_reg != OMODE_FILES);
    if (it.mode == ITEM_EOF) begin
      if ((omode_reg == OMODE_COUNT || omode_reg == OMODE_JSON) && selected_total != 0) begin
        beats[n] = make_line('0, KIND_FILE, 1'b0);
        n++;
      end
      reset_file_state();
    end else if (!file_done) begin
      sel = it.line_matched ^ invert_reg;
      if (line_no != '1) line_no++;
      if (sel) begin
        if (selected_total != '1) selected_total++;
        if (omode_reg == OMODE_FILES) begin
          beats[n] = make_line('0, KIND_FILE, 1'b0);
          n++;
          file_done = 1'b1;
        end else if (omode_reg != OMODE_COUNT) begin
          k   = (ring_fill < b) ? int'(ring_fill) : b;
          sep = text && omode_reg != OMODE_COMPACT && last_shown != 0 &&
                line_no > last_shown &&
                (longint'(line_no) - longint'(last_shown)) > longint'(a + b + 1);
          for (int unsigned j = 0; j < k; j++) begin
            idx = (int'(ring_head) + LCS_MAX_BEFORE - k + j) % LCS_MAX_BEFORE;
            ln  = ring_lines[idx];
            if (text) begin
              if (ln <= last_shown) continue;
              last_shown = ln;
            end
            beats[n] = make_line(ln, KIND_BEFORE, sep);
            n++;
            sep = 1'b0;
          end
          beats[n] = make_line(line_no, KIND_MATCH, sep);
          n++;
          if (text) last_shown = line_no;
          ring_fill  = '0;
          after_left = a[7:0];
        end
      end else if (after_left > 0) begin
        if (omode_reg != OMODE_COUNT && omode_reg != OMODE_FILES) begin
          beats[n] = make_line(line_no, KIND_AFTER, 1'b0);
          n++;
          if (text) last_shown = line_no;
        end
        after_left--;
      end else if (b > 0) begin
        ring_lines[ring_head] = line_no;
        ring_head++;
        if (ring_fill < LCS_MAX_BEFORE) ring_fill++;
      end
    end
    if (n > 0) beats[n-1].last = 1'b1;
    for (int unsigned j = 0; j < n; j++) pending_lines.push_back(beats[j]);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: beat %0d %s expected %0d actual %0d", $time, beats_checked, name,
               want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lines.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual line %0d kind %0d", $time,
                 out_data_o.line_num, out_data_o.kind);
      end else begin
        oldest_line = pending_lines.pop_front();
        check_field("line_num", oldest_line.line_num, out_data_o.line_num);
        check_field("kind", 32'(oldest_line.kind), 32'(out_data_o.kind));
        check_field("separator_before", 32'(oldest_line.separator_before),
                    32'(out_data_o.separator_before));
        check_field("match_count", oldest_line.match_count, out_data_o.match_count);
        check_field("last", 32'(oldest_line.last), 32'(out_data_o.last));
      end
      beats_checked++;
    end
  end

  // result-side backpressure
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        stall_left  = pick_gap();
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(lcs_in_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = it;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    select_lines(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (pending_lines.size() != 0);
  endtask

  task automatic wait_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [4:0] b, logic [7:0] a, logic [2:0] om, logic inv);
    logic [LCS_IDX_W-1:0] order [4];
    logic [LCS_CFG_W-1:0] vals [4];
    order = '{REG_BEFORE_COUNT, REG_AFTER_COUNT, REG_OUTPUT_MODE, REG_INVERT_MATCH};
    // unused upper data bits carry noise
    vals  = '{{3'($urandom), b}, a, {5'($urandom), om}, {7'($urandom), inv}};
    wait_quiet();
    for (int i = 0; i < 4; i++) begin
      cfg_index_i = order[i];
      cfg_data_i  = vals[i];
      cfg_valid_i = 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      commit_reg(order[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_item(line_item(1'b1));
    send_item(line_item(1'b0));
    send_item(eof_item());
  endtask

  task automatic test_text_context();
    apply_settings(5'd2, 8'd1, OMODE_TEXT, 1'b0);
    repeat (3) send_item(line_item(1'b0));
    send_item(line_item(1'b1));
    repeat (5) send_item(line_item(1'b0));
    send_item(line_item(1'b1));
    send_item(eof_item());
  endtask

  task automatic test_files_with_match();
    apply_settings(5'd3, 8'd4, OMODE_FILES, 1'b1);
    send_item(line_item(1'b1));
    send_item(line_item(1'b0));
    send_item(line_item(1'b0));
    send_item(eof_item());
  endtask

  task automatic test_json_records();
    apply_settings(5'd20, 8'd0, OMODE_JSON, 1'b0);
    send_item(line_item(1'b0));
    send_item(line_item(1'b0));
    send_item(line_item(1'b1));
    send_item(line_item(1'b0));
    send_item(eof_item());
  endtask

  task automatic test_count_records();
    apply_settings(5'd1, 8'd2, OMODE_COUNT, 1'b0);
    send_item(line_item(1'b1));
    send_item(line_item(1'b0));
    send_item(line_item(1'b1));
    wait_drained();
    send_item(eof_item());
    send_item(eof_item());
  endtask

  task automatic test_random_settings();
    logic [4:0]  b;
    logic [7:0]  a;
    logic [2:0]  om;
    logic        inv;
    int unsigned left;
    int unsigned file_len;
    int unsigned density;
    lcs_in_t     it;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       begin b = 5'd0;  a = 8'd0;   om = OMODE_TEXT;    inv = 1'b0; end
        1:       begin b = 5'd16; a = 8'd255; om = OMODE_TEXT;    inv = 1'b1; end
        2:       begin b = 5'd31; a = 8'd3;   om = OMODE_TEXT;    inv = 1'b0; end
        3:       begin b = 5'd4;  a = 8'd2;   om = OMODE_COMPACT; inv = 1'b0; end
        4:       begin b = 5'd17; a = 8'd0;   om = OMODE_JSON;    inv = 1'b1; end
        5:       begin b = 5'd5;  a = 8'd5;   om = OMODE_COUNT;   inv = 1'b1; end
        6:       begin b = 5'd3;  a = 8'd1;   om = OMODE_FILES;   inv = 1'b0; end
        7:       begin b = 5'd6;  a = 8'd2;   om = 3'd5;          inv = 1'b0; end
        8:       begin b = 5'd2;  a = 8'd7;   om = 3'd6;          inv = 1'b1; end
        9:       begin b = 5'd16; a = 8'd0;   om = 3'd7;          inv = 1'b1; end
        default: begin
          b   = 5'($urandom);
          a   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
          om  = 3'($urandom);
          inv = 1'($urandom);
        end
      endcase
      steady_flow = 1'b0;
      apply_settings(b, a, om, inv);
      steady_flow = ($urandom_range(0, 3) == 0);
      left = PHASE_ITEMS;
      while (left > 0) begin
        file_len = $urandom_range(3, 26);
        density  = $urandom_range(3, 45);
        for (int unsigned i = 0; i < file_len && left > 0; i++) begin
          it = line_item((($urandom_range(0, 99) < density) ? 1'b1 : 1'b0) ^ inv);
          if ($urandom_range(0, 99) < 8) it = lcs_in_t'($urandom);
          if ($urandom_range(0, 29) == 0) wait_drained();
          send_item(it);
          left--;
        end
        // the last file of a phase is sometimes left open across a settings change
        if (left > 0 || $urandom_range(0, 3) != 0) begin
          send_item(eof_item());
          if (left > 0) left--;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    steady_flow   = 1'b0;
    mismatches    = 0;
    beats_checked = 0;
    items_sent    = 0;
    settings_used = 0;
    cycles        = 0;
    before_reg    = '0;
    after_reg     = '0;
    omode_reg     = '0;
    invert_reg    = 1'b0;
    for (int i = 0; i < LCS_MAX_BEFORE; i++) ring_lines[i] = '0;
    reset_file_state();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_text_context();
    test_files_with_match();
    test_json_records();
    test_count_records();
    test_random_settings();

    wait_quiet();
    $display("Sent %0d line and end-of-file beats under %0d register settings,", items_sent,
             settings_used + 1);
    $display("checked %0d result beats over all output modes, inversion and context sizes.",
             beats_checked);
    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("[line_context_selector] OK");
    end else begin
      $display("[line_context_selector] ERROR");
    end
    $finish;
  end

endmodule
